// ===== design/gpb_pkg.sv =====
// ----------------------------------------------------------------------------
// gpb_pkg: shared types and constants of the gop packet budget calculator
// widths, register indexes, sequencer states and unit command records
// ----------------------------------------------------------------------------
package gpb_pkg;

   // transport packet size and arithmetic constants
   localparam int PKT_BYTES  = 188;
   localparam int NULL_DIV   = 25;
   localparam int NORM_SHIFT = 16 + 3;

   // serial multiplier widths
   localparam int MUL_A_W = 47;
   localparam int MUL_B_W = 40;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // serial divider widths
   localparam int DIV_N_W   = 64;
   localparam int DIV_D_W   = 19;
   localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

   // datapath widths
   localparam int RATE_W  = 47;
   localparam int GP_W    = 40;
   localparam int EXP_W   = 63;
   localparam int FOFS_W  = 40;
   localparam int PBP_W   = 36;
   localparam int NORM_W  = 29;
   localparam int RES_W   = 24;
   localparam int NC_W    = 18;
   localparam int MAXG_W  = 55;
   localparam int REQP_W  = 17;
   localparam int REQG_W  = 19;
   localparam int T_W     = 29;
   localparam int GOP_W   = 30;

   localparam logic [EXP_W-1:0] OFS_CAP = EXP_W'(1) << 62;

   // configuration register map
   localparam int CSR_ADDR_W = 5;
   typedef enum logic [2:0] {
      CSR_BPS    = 3'd0,
      CSR_SPP    = 3'd1,
      CSR_PICS   = 3'd2,
      CSR_PREFIX = 3'd3,
      CSR_DSM    = 3'd4,
      CSR_PSISET = 3'd5
   } csr_index_type;

   localparam logic [29:0] BPS_RESET    = 30'd3750000;
   localparam logic [16:0] SPP_RESET    = 17'd2185;
   localparam logic [7:0]  PICS_RESET   = 8'd2;
   localparam logic [3:0]  PSISET_RESET = 4'd3;

   typedef struct packed {
      logic [15:0] filtered_pic_pkts;
      logic [9:0]  psi_pkts;
      logic [9:0]  nc_frame_pkts;
      logic        pes_header_present;
      logic [31:0] out_pkt_count;
      logic [31:0] gop_in_index;
   } req_type;

   typedef struct packed {
      logic [23:0] gop_pkts;
      logic [23:0] pic_pkts;
      logic        skipped;
      logic [47:0] expected_offset;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] n;
      logic [DIV_D_W-1:0] d;
   } div_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RATE,
      ST_GPIC,
      ST_EXPECT,
      ST_FOFS,
      ST_PBYTE,
      ST_NORMAL,
      ST_RESERVE,
      ST_NCPKT,
      ST_MAXG,
      ST_DECIDE,
      ST_SHMUL,
      ST_SHDIV,
      ST_FINISH
   } state_type;

endpackage

// ===== design/gpb_mul.sv =====
// ----------------------------------------------------------------------------
// gpb_mul: bit-serial shift-and-add multiplier
// one multiplier bit per cycle, stops early once the remaining bits are zero
// ----------------------------------------------------------------------------
module gpb_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  gpb_pkg::mul_cmd_type        cmd,
   output logic                        done,
   output logic [gpb_pkg::MUL_P_W-1:0] prod
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [gpb_pkg::MUL_P_W-1:0] a_ff, a_in;
   logic [gpb_pkg::MUL_B_W-1:0] b_ff, b_in;
   logic [gpb_pkg::MUL_P_W-1:0] acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         a_in    = gpb_pkg::MUL_P_W'(cmd.a);
         b_in    = cmd.b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = a_ff << 1;
            b_in = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ===== design/gpb_div.sv =====
// ----------------------------------------------------------------------------
// gpb_div: bit-serial restoring divider
// one quotient bit per cycle over the full dividend width
// ----------------------------------------------------------------------------
module gpb_div (
   input  logic                        clock,
   input  logic                        reset,
   input  gpb_pkg::div_cmd_type        cmd,
   output logic                        done,
   output logic [gpb_pkg::DIV_N_W-1:0] quot
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [gpb_pkg::DIV_N_W-1:0]   q_ff, q_in;
   logic [gpb_pkg::DIV_D_W-1:0]   d_ff, d_in;
   logic [gpb_pkg::DIV_D_W-1:0]   rem_ff, rem_in;
   logic [gpb_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [gpb_pkg::DIV_D_W:0]     trial;
   logic [gpb_pkg::DIV_D_W:0]     diff;
   logic                          ge;

   assign trial = {rem_ff, q_ff[gpb_pkg::DIV_N_W-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign ge    = trial >= {1'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      q_in    = q_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         q_in    = cmd.n;
         d_in    = cmd.d;
         rem_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == gpb_pkg::DIV_CNT_W'(gpb_pkg::DIV_N_W)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            // remainder stays below the divisor, so the low bits suffice
            rem_in = ge ? diff[gpb_pkg::DIV_D_W-1:0] : trial[gpb_pkg::DIV_D_W-1:0];
            q_in   = {q_ff[gpb_pkg::DIV_N_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== design/gop_packet_budget_calculator.sv =====
// ----------------------------------------------------------------------------
// gop_packet_budget_calculator: per-keyframe packet budget of a fixed-gop file
// steps: the shared one-bit-per-cycle multiplier (seven products) and divider
//   (four quotients) run in turn; shorter multiplier operands or a skipped gop finish sooner
// items: a new item is taken only once the last result is out; busy is low again in the rsp_valid cycle
// reset: synchronous, active high; registers return to defaults, first gop pending
// the result is shown for one cycle only, the receiver cannot stall
// ----------------------------------------------------------------------------
module gop_packet_budget_calculator (
   input  logic                                clock,
   input  logic                                reset,
   // item channel
   input  logic                                start,
   output logic                                busy,
   input  gpb_pkg::req_type                    req_data,
   // result channel
   output logic                                rsp_valid,
   output gpb_pkg::rsp_type                    rsp_data,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gpb_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   // ---------------------------------------------------------------- csr
   logic [29:0] bps_ff;
   logic [16:0] spp_ff;
   logic [7:0]  pics_ff;
   logic        prefix_en_ff;
   logic        dsm_en_ff;
   logic [3:0]  psiset_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff       <= gpb_pkg::BPS_RESET;
         spp_ff       <= gpb_pkg::SPP_RESET;
         pics_ff      <= gpb_pkg::PICS_RESET;
         prefix_en_ff <= 1'b0;
         dsm_en_ff    <= 1'b0;
         psiset_ff    <= gpb_pkg::PSISET_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            gpb_pkg::CSR_BPS:    bps_ff       <= pwdata[29:0];
            gpb_pkg::CSR_SPP:    spp_ff       <= pwdata[16:0];
            gpb_pkg::CSR_PICS:   pics_ff      <= pwdata[7:0];
            gpb_pkg::CSR_PREFIX: prefix_en_ff <= pwdata[0];
            gpb_pkg::CSR_DSM:    dsm_en_ff    <= pwdata[0];
            gpb_pkg::CSR_PSISET: psiset_ff    <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         gpb_pkg::CSR_BPS:    prdata = 32'(bps_ff);
         gpb_pkg::CSR_SPP:    prdata = 32'(spp_ff);
         gpb_pkg::CSR_PICS:   prdata = 32'(pics_ff);
         gpb_pkg::CSR_PREFIX: prdata = 32'(prefix_en_ff);
         gpb_pkg::CSR_DSM:    prdata = 32'(dsm_en_ff);
         gpb_pkg::CSR_PSISET: prdata = 32'(psiset_ff);
         default:             prdata = '0;
      endcase
   end

   // zero pictures per gop counts as one
   logic [7:0] pics_eff;
   assign pics_eff = (pics_ff == '0) ? 8'd1 : pics_ff;

   // ---------------------------------------------------------------- arithmetic units
   gpb_pkg::mul_cmd_type               mul_cmd;
   gpb_pkg::div_cmd_type               div_cmd;
   logic                               mul_done, div_done;
   logic [gpb_pkg::MUL_P_W-1:0]        mul_prod;
   logic [gpb_pkg::DIV_N_W-1:0]        div_quot;

   gpb_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   gpb_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .done  (div_done),
      .quot  (div_quot)
   );

   // ---------------------------------------------------------------- sequencer state
   gpb_pkg::state_type state_ff, state_in;
   logic               launched_ff, launched_in;
   logic               pending_ff, pending_in;
   logic               rsp_valid_ff, rsp_valid_in;
   gpb_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // latched item
   logic [9:0]  ncf_ff, ncf_in;
   logic [31:0] ocnt_ff, ocnt_in;
   logic [31:0] gidx_ff, gidx_in;
   logic [gpb_pkg::REQP_W-1:0] reqp_ff, reqp_in;

   // intermediate results
   logic [gpb_pkg::RATE_W-1:0] rate_ff, rate_in;
   logic [gpb_pkg::GP_W-1:0]   gp_ff, gp_in;
   logic [gpb_pkg::EXP_W-1:0]  exp_ff, exp_in;
   logic [gpb_pkg::FOFS_W-1:0] fofs_ff, fofs_in;
   logic [gpb_pkg::PBP_W-1:0]  pbp_ff, pbp_in;
   logic [gpb_pkg::NORM_W-1:0] norm_ff, norm_in;
   logic [gpb_pkg::RES_W-1:0]  res_ff, res_in;
   logic [gpb_pkg::NC_W-1:0]   nc_ff, nc_in;
   logic [gpb_pkg::MAXG_W-1:0] maxg_ff, maxg_in;
   logic [gpb_pkg::T_W-1:0]    t_ff, t_in;
   logic [46:0]                shp_ff, shp_in;
   logic [gpb_pkg::T_W-1:0]    share_ff, share_in;
   logic                       used_ff, used_in;

   // ---------------------------------------------------------------- combinational helpers
   logic [16:0]                req_pic_new;
   logic [gpb_pkg::REQG_W-1:0] req_gop;
   logic [25:0]                need;
   logic [67:0]                prod_shr;
   logic [gpb_pkg::EXP_W-1:0]  exp_new;
   logic                       neg_room;
   logic [gpb_pkg::MAXG_W-1:0] tmin;
   logic [gpb_pkg::GOP_W-1:0]  gop_val;
   logic [gpb_pkg::GOP_W-1:0]  pic_raw;
   logic [gpb_pkg::GOP_W-1:0]  pic_val;
   logic [3:0]                 prefix;
   logic                       pes;

   assign prefix      = (pending_ff && prefix_en_ff) ? psiset_ff : 4'd0;
   assign pes         = !req_data.pes_header_present || dsm_en_ff;
   assign req_pic_new = 17'(prefix) + 17'(req_data.filtered_pic_pkts) + 17'(pes)
                        + 17'(req_data.psi_pkts);
   assign req_gop     = gpb_pkg::REQG_W'(reqp_ff) + gpb_pkg::REQG_W'(nc_ff);
   assign need        = 26'(req_gop) + 26'(res_ff);

   // expected offset is the product shifted down, capped at 2^62
   assign prod_shr = mul_prod[gpb_pkg::MUL_P_W-1:gpb_pkg::NORM_SHIFT];
   assign exp_new  = (prod_shr > 68'(gpb_pkg::OFS_CAP)) ? gpb_pkg::OFS_CAP
                                                        : prod_shr[gpb_pkg::EXP_W-1:0];
   assign neg_room = exp_ff < gpb_pkg::EXP_W'(fofs_ff);

   assign tmin    = (maxg_ff < gpb_pkg::MAXG_W'(norm_ff)) ? maxg_ff
                                                          : gpb_pkg::MAXG_W'(norm_ff);
   assign gop_val = used_ff ? (gpb_pkg::GOP_W'(t_ff) + gpb_pkg::GOP_W'(res_ff)) : '0;
   assign pic_raw = gpb_pkg::GOP_W'(share_ff) + gpb_pkg::GOP_W'(res_ff);
   assign pic_val = !used_ff ? '0 :
                    ((gop_val - pic_raw) < gpb_pkg::GOP_W'(nc_ff))
                       ? (gop_val - gpb_pkg::GOP_W'(nc_ff)) : pic_raw;

   // ---------------------------------------------------------------- unit operands by step
   logic is_mul, is_div;

   always_comb begin
      is_mul = 1'b0;
      is_div = 1'b0;
      mul_cmd = '0;
      div_cmd = '0;
      case (state_ff)
         gpb_pkg::ST_RATE: begin
            is_mul = 1'b1;
            mul_cmd.a = gpb_pkg::MUL_A_W'(bps_ff);
            mul_cmd.b = gpb_pkg::MUL_B_W'(spp_ff);
         end
         gpb_pkg::ST_GPIC: begin
            is_mul = 1'b1;
            mul_cmd.a = (gidx_ff == '0) ? gpb_pkg::MUL_A_W'(1) : gpb_pkg::MUL_A_W'(gidx_ff);
            mul_cmd.b = gpb_pkg::MUL_B_W'(pics_eff);
         end
         gpb_pkg::ST_EXPECT: begin
            is_mul = 1'b1;
            mul_cmd.a = rate_ff;
            mul_cmd.b = gp_ff;
         end
         gpb_pkg::ST_FOFS: begin
            is_mul = 1'b1;
            mul_cmd.a = gpb_pkg::MUL_A_W'(ocnt_ff);
            mul_cmd.b = gpb_pkg::MUL_B_W'(gpb_pkg::PKT_BYTES);
         end
         gpb_pkg::ST_PBYTE: begin
            is_mul = 1'b1;
            mul_cmd.a = gpb_pkg::MUL_A_W'(rate_ff[gpb_pkg::RATE_W-1:gpb_pkg::NORM_SHIFT]);
            mul_cmd.b = gpb_pkg::MUL_B_W'(pics_eff);
         end
         gpb_pkg::ST_NCPKT: begin
            is_mul = 1'b1;
            mul_cmd.a = gpb_pkg::MUL_A_W'(ncf_ff);
            mul_cmd.b = gpb_pkg::MUL_B_W'(pics_eff - 8'd1);
         end
         gpb_pkg::ST_SHMUL: begin
            is_mul = 1'b1;
            mul_cmd.a = gpb_pkg::MUL_A_W'(t_ff);
            mul_cmd.b = gpb_pkg::MUL_B_W'(reqp_ff);
         end
         gpb_pkg::ST_NORMAL: begin
            is_div = 1'b1;
            div_cmd.n = gpb_pkg::DIV_N_W'(pbp_ff) + gpb_pkg::DIV_N_W'(gpb_pkg::PKT_BYTES - 1);
            div_cmd.d = gpb_pkg::DIV_D_W'(gpb_pkg::PKT_BYTES);
         end
         gpb_pkg::ST_RESERVE: begin
            is_div = 1'b1;
            div_cmd.n = gpb_pkg::DIV_N_W'(norm_ff);
            div_cmd.d = gpb_pkg::DIV_D_W'(gpb_pkg::NULL_DIV);
         end
         gpb_pkg::ST_MAXG: begin
            is_div = !neg_room;
            div_cmd.n = gpb_pkg::DIV_N_W'(exp_ff) - gpb_pkg::DIV_N_W'(fofs_ff)
                        + gpb_pkg::DIV_N_W'(gpb_pkg::PKT_BYTES - 1);
            div_cmd.d = gpb_pkg::DIV_D_W'(gpb_pkg::PKT_BYTES);
         end
         gpb_pkg::ST_SHDIV: begin
            is_div = req_gop != '0;
            div_cmd.n = gpb_pkg::DIV_N_W'(shp_ff) + gpb_pkg::DIV_N_W'(req_gop)
                        - gpb_pkg::DIV_N_W'(1);
            div_cmd.d = req_gop;
         end
         default: ;
      endcase
      mul_cmd.start = is_mul && !launched_ff;
      div_cmd.start = is_div && !launched_ff;
   end

   // ---------------------------------------------------------------- next state and captures
   always_comb begin
      state_in     = state_ff;
      launched_in  = launched_ff;
      pending_in   = pending_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ncf_in   = ncf_ff;
      ocnt_in  = ocnt_ff;
      gidx_in  = gidx_ff;
      reqp_in  = reqp_ff;
      rate_in  = rate_ff;
      gp_in    = gp_ff;
      exp_in   = exp_ff;
      fofs_in  = fofs_ff;
      pbp_in   = pbp_ff;
      norm_in  = norm_ff;
      res_in   = res_ff;
      nc_in    = nc_ff;
      maxg_in  = maxg_ff;
      t_in     = t_ff;
      shp_in   = shp_ff;
      share_in = share_ff;
      used_in  = used_ff;

      // each unit step: launch once, then wait for the unit's done
      if ((is_mul || is_div) && !launched_ff) begin
         launched_in = 1'b1;
      end

      case (state_ff)
         gpb_pkg::ST_IDLE: begin
            if (start) begin
               ncf_in      = req_data.nc_frame_pkts;
               ocnt_in     = req_data.out_pkt_count;
               gidx_in     = req_data.gop_in_index;
               reqp_in     = req_pic_new;
               launched_in = 1'b0;
               state_in    = gpb_pkg::ST_RATE;
            end
         end
         gpb_pkg::ST_RATE: begin
            if (launched_ff && mul_done) begin
               rate_in     = mul_prod[gpb_pkg::RATE_W-1:0];
               launched_in = 1'b0;
               state_in    = gpb_pkg::ST_GPIC;
            end
         end
         gpb_pkg::ST_GPIC: begin
            if (launched_ff && mul_done) begin
               gp_in       = mul_prod[gpb_pkg::GP_W-1:0];
               launched_in = 1'b0;
               state_in    = gpb_pkg::ST_EXPECT;
            end
         end
         gpb_pkg::ST_EXPECT: begin
            if (launched_ff && mul_done) begin
               exp_in      = exp_new;
               launched_in = 1'b0;
               state_in    = gpb_pkg::ST_FOFS;
            end
         end
         gpb_pkg::ST_FOFS: begin
            if (launched_ff && mul_done) begin
               fofs_in     = mul_prod[gpb_pkg::FOFS_W-1:0];
               launched_in = 1'b0;
               state_in    = gpb_pkg::ST_PBYTE;
            end
         end
         gpb_pkg::ST_PBYTE: begin
            if (launched_ff && mul_done) begin
               pbp_in      = mul_prod[gpb_pkg::PBP_W-1:0];
               launched_in = 1'b0;
               state_in    = gpb_pkg::ST_NORMAL;
            end
         end
         gpb_pkg::ST_NORMAL: begin
            if (launched_ff && div_done) begin
               norm_in     = div_quot[gpb_pkg::NORM_W-1:0];
               launched_in = 1'b0;
               state_in    = gpb_pkg::ST_RESERVE;
            end
         end
         gpb_pkg::ST_RESERVE: begin
            if (launched_ff && div_done) begin
               res_in      = div_quot[gpb_pkg::RES_W-1:0];
               launched_in = 1'b0;
               state_in    = gpb_pkg::ST_NCPKT;
            end
         end
         gpb_pkg::ST_NCPKT: begin
            if (launched_ff && mul_done) begin
               nc_in       = mul_prod[gpb_pkg::NC_W-1:0];
               launched_in = 1'b0;
               state_in    = gpb_pkg::ST_MAXG;
            end
         end
         gpb_pkg::ST_MAXG: begin
            // expected offset behind the file offset: gop skipped
            if (neg_room) begin
               used_in     = 1'b0;
               launched_in = 1'b0;
               state_in    = gpb_pkg::ST_FINISH;
            end else if (launched_ff && div_done) begin
               maxg_in     = div_quot[gpb_pkg::MAXG_W-1:0];
               launched_in = 1'b0;
               state_in    = gpb_pkg::ST_DECIDE;
            end
         end
         gpb_pkg::ST_DECIDE: begin
            if (maxg_ff >= gpb_pkg::MAXG_W'(need)) begin
               used_in  = 1'b1;
               t_in     = (tmin >= gpb_pkg::MAXG_W'(need)) ? tmin[gpb_pkg::T_W-1:0]
                                                           : gpb_pkg::T_W'(req_gop);
               state_in = gpb_pkg::ST_SHMUL;
            end else begin
               used_in  = 1'b0;
               state_in = gpb_pkg::ST_FINISH;
            end
         end
         gpb_pkg::ST_SHMUL: begin
            if (launched_ff && mul_done) begin
               shp_in      = mul_prod[46:0];
               launched_in = 1'b0;
               state_in    = gpb_pkg::ST_SHDIV;
            end
         end
         gpb_pkg::ST_SHDIV: begin
            // no required content: key picture share is zero
            if (req_gop == '0) begin
               share_in    = '0;
               launched_in = 1'b0;
               state_in    = gpb_pkg::ST_FINISH;
            end else if (launched_ff && div_done) begin
               share_in    = div_quot[gpb_pkg::T_W-1:0];
               launched_in = 1'b0;
               state_in    = gpb_pkg::ST_FINISH;
            end
         end
         gpb_pkg::ST_FINISH: begin
            rsp_data_in.gop_pkts = (gop_val[gpb_pkg::GOP_W-1:24] != '0) ? 24'hFFFFFF
                                                                     : gop_val[23:0];
            rsp_data_in.pic_pkts = (pic_val[gpb_pkg::GOP_W-1:24] != '0) ? 24'hFFFFFF
                                                                     : pic_val[23:0];
            rsp_data_in.skipped  = gop_val == '0;
            rsp_data_in.expected_offset = (exp_ff[gpb_pkg::EXP_W-1:48] != '0) ?
                                          48'hFFFF_FFFF_FFFF : exp_ff[47:0];
            // an empty budget keeps the prefix psi waiting
            if (gop_val != '0) begin
               pending_in = 1'b0;
            end
            rsp_valid_in = 1'b1;
            state_in     = gpb_pkg::ST_IDLE;
         end
         default: state_in = gpb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gpb_pkg::ST_IDLE;
         launched_ff  <= 1'b0;
         pending_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      ncf_ff   <= ncf_in;
      ocnt_ff  <= ocnt_in;
      gidx_ff  <= gidx_in;
      reqp_ff  <= reqp_in;
      rate_ff  <= rate_in;
      gp_ff    <= gp_in;
      exp_ff   <= exp_in;
      fofs_ff  <= fofs_in;
      pbp_ff   <= pbp_in;
      norm_ff  <= norm_in;
      res_ff   <= res_in;
      nc_ff    <= nc_in;
      maxg_ff  <= maxg_in;
      t_ff     <= t_in;
      shp_ff   <= shp_in;
      share_ff <= share_in;
      used_ff  <= used_in;
   end

   assign busy      = state_ff != gpb_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- assertions
   a_rsp_after_finish : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == gpb_pkg::ST_FINISH))
      else $error("result strobe without finishing step");

   a_skip_consistent : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.skipped == (rsp_data_ff.gop_pkts == '0)))
      else $error("skip flag disagrees with gop budget");

   a_pic_within_gop : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.pic_pkts <= rsp_data_ff.gop_pkts))
      else $error("key picture budget exceeds gop budget");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start work");

   a_pending_never_rises : assert property (@(posedge clock) disable iff (reset)
      !$rose(pending_ff))
      else $error("first gop flag set again outside reset");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the gop packet budget calculator
// items are driven through the start/busy channel and every result strobe is
// compared field by field against an in-bench budget model, over several
// register settings written through the csr port while the block is idle
// ----------------------------------------------------------------------------
module tb_top;

   localparam int SETTLE_CYCLES = 450;     // idle wait after the last result is drained
   localparam int WATCHDOG_MAX  = 20000;   // cycles without any accepted transfer
   localparam int PHASES        = 7;
   localparam int RAND_PER_PHASE = 270;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   gpb_pkg::req_type req_data = '0;
   logic             rsp_valid;
   gpb_pkg::rsp_type rsp_data;
   logic             psel = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite = 1'b0;
   logic [gpb_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]      pwdata = '0;
   logic [31:0]      prdata;
   logic             pready;

   // shadow copy of the block's registers and state
   logic [29:0]      bps_reg;
   logic [16:0]      spp_reg;
   logic [7:0]       pics_reg;
   logic             prefix_reg;
   logic             dsm_reg;
   logic [3:0]       psiset_reg;
   logic             first_pending;

   gpb_pkg::req_type item_q[$];
   gpb_pkg::rsp_type budget_q[$];
   int unsigned      n_queued = 0;
   int unsigned      n_taken = 0;
   int unsigned      err_cnt = 0;
   int unsigned      idle_cycles = 0;
   int unsigned      gap_cnt = 0;
   logic             calm = 1'b0;        // no sender idling in the last phase
   logic             csr_busy = 1'b0;

   gop_packet_budget_calculator dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // pictures per gop, zero read as one
   function automatic logic [63:0] eff_pics();
      return (pics_reg == 8'd0) ? 64'd1 : {56'd0, pics_reg};
   endfunction

   function automatic logic [63:0] normal_pkts();
      logic [63:0] rate;
      rate = {34'd0, bps_reg} * {47'd0, spp_reg};
      return ((rate >> gpb_pkg::NORM_SHIFT) * eff_pics() + 64'd187) / 64'd188;
   endfunction

   // expected byte offset at the end of gop idx, capped at 2^62
   function automatic logic [63:0] gop_offset(logic [31:0] idx);
      logic [127:0] prod;
      logic [127:0] shifted;
      logic [63:0]  rate;
      rate = {34'd0, bps_reg} * {47'd0, spp_reg};
      if (idx == 32'd0) idx = 32'd1;
      prod = ({96'd0, idx} * {64'd0, eff_pics()}) * {64'd0, rate};
      shifted = prod >> gpb_pkg::NORM_SHIFT;
      if (shifted > (128'd1 << 62)) return 64'd1 << 62;
      return shifted[63:0];
   endfunction

   // budget of one keyframe; also advances the first-gop flag
   function automatic gpb_pkg::rsp_type budget_predict(gpb_pkg::req_type r);
      gpb_pkg::rsp_type o;
      logic [63:0] pics, prefix, pes, nc, req_pic, req_gop, normal, reserve;
      logic [63:0] expected, file_ofs, maxg, t, share, gop, pic;
      pics = eff_pics();
      prefix = (first_pending && prefix_reg) ? {60'd0, psiset_reg} : 64'd0;
      pes = (!r.pes_header_present || dsm_reg) ? 64'd1 : 64'd0;
      nc = {54'd0, r.nc_frame_pkts} * (pics - 64'd1);
      req_pic = prefix + {48'd0, r.filtered_pic_pkts} + pes + {54'd0, r.psi_pkts};
      req_gop = req_pic + nc;
      normal = normal_pkts();
      reserve = normal / 64'(gpb_pkg::NULL_DIV);
      expected = gop_offset(r.gop_in_index);
      file_ofs = {32'd0, r.out_pkt_count} * 64'd188;
      gop = 64'd0;
      pic = 64'd0;
      // negative headroom leaves the gop skipped
      if (expected >= file_ofs) begin
         maxg = (expected - file_ofs + 64'd187) / 64'd188;
         if (maxg >= req_gop + reserve) begin
            t = (maxg < normal) ? maxg : normal;
            if (t < req_gop + reserve) t = req_gop;
            gop = t + reserve;
            share = (req_gop == 64'd0) ? 64'd0 : (t * req_pic + req_gop - 64'd1) / req_gop;
            pic = share + reserve;
            // keep room for the no-change pictures
            if (gop - pic < nc) pic = gop - nc;
         end
      end
      // an empty budget counts as a skip and keeps the first-gop flag
      if (gop == 64'd0) pic = 64'd0;
      else first_pending = 1'b0;
      o.gop_pkts = (gop > 64'hFFFFFF) ? 24'hFFFFFF : gop[23:0];
      o.pic_pkts = (pic > 64'hFFFFFF) ? 24'hFFFFFF : pic[23:0];
      o.skipped = (gop == 64'd0);
      o.expected_offset = (expected > 64'hFFFFFFFFFFFF) ? 48'hFFFFFFFFFFFF : expected[47:0];
      return o;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
      err_cnt++;
   endtask

   // sender: holds an item until taken, idles in random bursts
   always @(posedge clock) begin : driver
      logic took;
      if (reset) begin
         start <= 1'b0;
         gap_cnt <= 0;
      end else begin
         took = start && !busy;
         if (took) begin
            budget_q.push_back(budget_predict(req_data));
            n_taken++;
         end
         if (start && !took) begin
            // keep holding the item
         end else if (gap_cnt != 0) begin
            gap_cnt <= gap_cnt - 1;
            start <= 1'b0;
         end else if (item_q.size() != 0) begin
            req_data <= item_q.pop_front();
            start <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) gap_cnt <= $urandom_range(1, 16);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result side: one strobe per item, checked against the oldest budget
   always @(posedge clock) begin : monitor
      gpb_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (budget_q.size() == 0) begin
               report("result with no item outstanding", 64'd1, 64'd0);
            end else begin
               want = budget_q.pop_front();
               if (rsp_data.gop_pkts !== want.gop_pkts)
                  report("gop_pkts", rsp_data.gop_pkts, want.gop_pkts);
               if (rsp_data.pic_pkts !== want.pic_pkts)
                  report("pic_pkts", rsp_data.pic_pkts, want.pic_pkts);
               if (rsp_data.skipped !== want.skipped)
                  report("skipped", rsp_data.skipped, want.skipped);
               if (rsp_data.expected_offset !== want.expected_offset)
                  report("expected_offset", rsp_data.expected_offset, want.expected_offset);
            end
         end
         // watchdog on any transfer
         if (rsp_valid || (start && !busy) || csr_busy) idle_cycles <= 0;
         else if (idle_cycles + 1 >= WATCHDOG_MAX) begin
            $display("tb_top failed");
            $finish;
         end else idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic csr_write(gpb_pkg::csr_index_type idx, logic [31:0] value);
      csr_busy = 1'b1;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         gpb_pkg::CSR_BPS:    bps_reg = value[29:0];
         gpb_pkg::CSR_SPP:    spp_reg = value[16:0];
         gpb_pkg::CSR_PICS:   pics_reg = value[7:0];
         gpb_pkg::CSR_PREFIX: prefix_reg = value[0];
         gpb_pkg::CSR_DSM:    dsm_reg = value[0];
         gpb_pkg::CSR_PSISET: psiset_reg = value[3:0];
         default: ;
      endcase
      csr_busy = 1'b0;
   endtask

   task automatic queue_item(gpb_pkg::req_type r);
      item_q.push_back(r);
      n_queued++;
   endtask

   // well-formed keyframe: output count near the expected offset, modest content
   function automatic gpb_pkg::req_type keyframe_item();
      gpb_pkg::req_type r;
      logic [63:0] norm, lim, base, back;
      norm = normal_pkts();
      lim = (norm > 64'd60000) ? 64'd60000 : norm;
      r.gop_in_index = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5000);
      if ($urandom_range(0, 3) == 0) begin
         // nothing to carry but the header
         r.filtered_pic_pkts = '0;
         r.psi_pkts = '0;
         r.nc_frame_pkts = '0;
         r.pes_header_present = 1'b1;
      end else begin
         r.filtered_pic_pkts = 16'($urandom_range(0, int'(lim / 2) + 2));
         r.psi_pkts = 10'($urandom_range(0, 12));
         r.nc_frame_pkts = 10'($urandom_range(0, 20));
         r.pes_header_present = 1'($urandom);
      end
      base = gop_offset(r.gop_in_index) / 64'd188;
      back = 64'($urandom_range(0, 3 * int'(lim) + 40));
      base = (base > back) ? base - back : 64'd0;
      r.out_pkt_count = base[31:0] + 32'($urandom_range(0, 3));
      return r;
   endfunction

   function automatic gpb_pkg::req_type noise_item();
      gpb_pkg::req_type r;
      r.filtered_pic_pkts = 16'($urandom);
      r.psi_pkts = 10'($urandom);
      r.nc_frame_pkts = 10'($urandom);
      r.pes_header_present = 1'($urandom);
      r.out_pkt_count = $urandom;
      r.gop_in_index = $urandom;
      return r;
   endfunction

   task automatic wait_drained();
      while (!(n_taken == n_queued && budget_q.size() == 0)) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [29:0] bps_set [PHASES] = '{30'd3750000, 30'd1000000000, 30'd1, 30'd20000000,
                                        30'd8000000, 30'd3750000, 30'd3750000};
      logic [16:0] spp_set [PHASES] = '{17'd2185, 17'd65536, 17'd1, 17'd2185,
                                        17'd4370, 17'd1500, 17'd2185};
      logic [7:0]  pics_set [PHASES] = '{8'd2, 8'd255, 8'd1, 8'd0, 8'd15, 8'd6, 8'd2};
      logic        prefix_set [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
      logic        dsm_set [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
      logic [3:0]  psi_set [PHASES] = '{4'd15, 4'd0, 4'd7, 4'd3, 4'd9, 4'd1, 4'd3};
      gpb_pkg::req_type r;
      bps_reg = gpb_pkg::BPS_RESET;
      spp_reg = gpb_pkg::SPP_RESET;
      pics_reg = gpb_pkg::PICS_RESET;
      prefix_reg = 1'b0;
      dsm_reg = 1'b0;
      psiset_reg = gpb_pkg::PSISET_RESET;
      first_pending = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         if (p == PHASES - 1) calm = 1'b1;
         if (p == 5) begin
            // one randomly chosen setting
            bps_set[p] = 30'($urandom_range(1, 1000000000));
            spp_set[p] = 17'($urandom_range(1, 65536));
            pics_set[p] = 8'($urandom_range(1, 255));
         end
         csr_write(gpb_pkg::CSR_BPS, {2'd0, bps_set[p]});
         csr_write(gpb_pkg::CSR_SPP, {15'd0, spp_set[p]});
         csr_write(gpb_pkg::CSR_PICS, {24'd0, pics_set[p]});
         csr_write(gpb_pkg::CSR_PREFIX, {31'd0, prefix_set[p]});
         csr_write(gpb_pkg::CSR_DSM, {31'd0, dsm_set[p]});
         csr_write(gpb_pkg::CSR_PSISET, {28'd0, psi_set[p]});
         if (p == 0) begin
            // zero gop index and empty content, first gop carries the prefix set
            r = '0;
            queue_item(r);
            // every field at its top value
            r.filtered_pic_pkts = '1;
            r.psi_pkts = '1;
            r.nc_frame_pkts = '1;
            r.pes_header_present = 1'b1;
            r.out_pkt_count = '1;
            r.gop_in_index = '1;
            queue_item(r);
            // negative headroom: far more written than expected
            r = '0;
            r.gop_in_index = 32'd1;
            r.out_pkt_count = 32'd1000000;
            queue_item(r);
            // nothing required at all, key share is zero
            r = '0;
            r.pes_header_present = 1'b1;
            r.gop_in_index = 32'd10;
            queue_item(r);
            // top index with nothing written yet
            r.gop_in_index = '1;
            r.filtered_pic_pkts = 16'hFFFF;
            queue_item(r);
            for (int k = 0; k < 12; k++) queue_item(keyframe_item());
            // sender holds off until everything has come back
            wait_drained();
         end
         for (int k = 0; k < RAND_PER_PHASE; k++)
            queue_item(($urandom_range(0, 7) == 0) ? noise_item() : keyframe_item());
      end
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (err_cnt == 0 && budget_q.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
